// ===== hw/rtl/bsa_pkg.sv =====
// Shared types and constants of the bitmap slot allocator.
package bsa_pkg;

   localparam int WORD_BITS  = 64;
   localparam int BIT_W      = 6;
   localparam int IDX_W      = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int STRIDE_W   = 13;
   localparam int KIND_W     = 2;
   localparam int CAP_W      = 11;
   localparam int STATUS_W   = 2;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_ALLOCATED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FREED     = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_CPU_BASE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GPU_BASE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SLOT_STRIDE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HEAP_KIND   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CAPACITY    = 3'd4;

   localparam logic [STRIDE_W-1:0] STRIDE_RESET   = 13'd32;
   localparam logic [CAP_W-1:0]    CAPACITY_RESET = 11'd1024;
   localparam logic [KIND_W-1:0]   KIND_LAST_GPU  = 2'd1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;      // latch the request payload
      logic rd_first;    // point the scan at word zero
      logic rd_next;     // advance the scan by one word
      logic rd_free;     // read the word named by the incoming free
      logic take_hit;    // clear the found bit and hold the slot
      logic do_free;     // write back the word with the freed bit set
      logic do_mul;      // form slot times stride
      logic load_alloc;  // load the allocation result
      logic load_full;   // load the heap full result
      logic load_freed;  // load the freed result
   } bsa_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hit;         // the current word holds a usable free slot
      logic last_word;   // the current word is the last of the bitmap
   } bsa_sts_type;

endpackage

// ===== hw/rtl/bsa_ram.sv =====
// Generic single-port-write, registered-read RAM.
module bsa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bsa_datapath.sv =====
// Datapath: configuration registers, bitmap store, bit search and handle arithmetic.
module bsa_datapath #(
   parameter int NUM_WORDS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bsa_pkg::bsa_cmd_type              cmd,
   output bsa_pkg::bsa_sts_type              sts,
   input  logic [bsa_pkg::IDX_W-1:0]         req_free_index,
   input  logic                              csr_write,
   input  logic [bsa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [63:0]                       csr_wdata,
   output logic [bsa_pkg::IDX_W-1:0]         rsp_slot_index,
   output logic [63:0]                       rsp_cpu_addr,
   output logic [63:0]                       rsp_gpu_addr,
   output logic [bsa_pkg::STATUS_W-1:0]      rsp_status
);
   import bsa_pkg::*;

   localparam int WIDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int SLOT_W = WIDX_W + BIT_W;
   localparam int PROD_W = SLOT_W + STRIDE_W;
   localparam int CMP_W  = ((SLOT_W > CAP_W) ? SLOT_W : CAP_W) + 1;
   localparam int FW_W   = IDX_W - BIT_W;

   // Configuration registers.
   logic [63:0]          cpu_base_ff, gpu_base_ff;
   logic [STRIDE_W-1:0]  stride_ff;
   logic [KIND_W-1:0]    kind_ff;
   logic [CAP_W-1:0]     cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cpu_base_ff <= '0;
         gpu_base_ff <= '0;
         stride_ff   <= STRIDE_RESET;
         kind_ff     <= '0;
         cap_ff      <= CAPACITY_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_CPU_BASE:    cpu_base_ff <= csr_wdata;
            REG_GPU_BASE:    gpu_base_ff <= csr_wdata;
            REG_SLOT_STRIDE: stride_ff   <= csr_wdata[STRIDE_W-1:0];
            REG_HEAP_KIND:   kind_ff     <= csr_wdata[KIND_W-1:0];
            REG_CAPACITY:    cap_ff      <= csr_wdata[CAP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Request latch and scan pointer.
   logic [IDX_W-1:0]  free_idx_ff;
   logic [WIDX_W-1:0] wcnt_ff, wcnt_in;
   logic [FW_W-1:0]   port_fw, held_fw;
   logic              port_in_range, held_in_range;
   logic [WIDX_W-1:0] rd_addr, free_addr;

   assign port_fw       = req_free_index[IDX_W-1:BIT_W];
   assign held_fw       = free_idx_ff[IDX_W-1:BIT_W];
   assign port_in_range = (9'(port_fw) < 9'(NUM_WORDS));
   assign held_in_range = (9'(held_fw) < 9'(NUM_WORDS));
   assign free_addr     = held_in_range ? WIDX_W'(held_fw) : '0;

   always_comb begin
      wcnt_in = wcnt_ff;
      if (cmd.rd_first) begin
         wcnt_in = '0;
      end else if (cmd.rd_next) begin
         wcnt_in = wcnt_ff + WIDX_W'(1);
      end
      rd_addr = wcnt_in;
      if (cmd.rd_free) begin
         rd_addr = port_in_range ? WIDX_W'(port_fw) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wcnt_ff <= '0;
      end else begin
         wcnt_ff <= wcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         free_idx_ff <= req_free_index;
      end
   end

   // Bitmap store; a word never written reads as all free.
   logic                 word_valid_ff [NUM_WORDS];
   logic                 rd_valid_ff;
   logic                 wr_en;
   logic [WIDX_W-1:0]    wr_addr;
   logic [WORD_BITS-1:0] wr_data, rd_raw, rd_word;

   bsa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NUM_WORDS),
      .ADDR_W(WIDX_W)
   ) u_bitmap (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_raw)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_WORDS; i++) begin
            word_valid_ff[i] <= 1'b0;
         end
      end else if (wr_en) begin
         word_valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= word_valid_ff[rd_addr];
   end

   assign rd_word = rd_valid_ff ? rd_raw : '1;

   // Usable mask of the current word, then lowest set bit.
   logic [CMP_W-1:0]     base, cap_ext, left;
   logic [WORD_BITS-1:0] usable, bits, lowbit;
   logic [BIT_W-1:0]     bit_idx;

   always_comb begin
      base    = CMP_W'({wcnt_ff, {BIT_W{1'b0}}});
      cap_ext = CMP_W'(cap_ff);
      left    = cap_ext - base;
      if (cap_ext <= base) begin
         usable = '0;
      end else if (left >= CMP_W'(WORD_BITS)) begin
         usable = '1;
      end else begin
         usable = {WORD_BITS{1'b1}} >> (7'(WORD_BITS) - 7'(left));
      end
      bits   = rd_word & usable;
      lowbit = bits & (~bits + 64'd1);
      bit_idx = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (lowbit[i]) begin
            bit_idx = bit_idx | BIT_W'(i);
         end
      end
   end

   assign sts.hit       = |bits;
   assign sts.last_word = (wcnt_ff == WIDX_W'(NUM_WORDS - 1));

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = wcnt_ff;
      wr_data = rd_word & ~lowbit;
      if (cmd.take_hit) begin
         wr_en = 1'b1;
      end else if (cmd.do_free) begin
         wr_en   = held_in_range;
         wr_addr = free_addr;
         wr_data = rd_word | (64'd1 << free_idx_ff[BIT_W-1:0]);
      end
   end

   // Slot, offset and result registers.
   logic [SLOT_W-1:0]   slot_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [63:0]         offset;
   logic [IDX_W-1:0]    slot_idx_ff;
   logic [63:0]         cpu_ff, gpu_ff;
   logic [STATUS_W-1:0] status_ff;

   assign offset = 64'(prod_ff);

   always_ff @(posedge clock) begin
      if (cmd.take_hit) begin
         slot_ff <= {wcnt_ff, bit_idx};
      end
      if (cmd.do_mul) begin
         prod_ff <= PROD_W'(slot_ff) * PROD_W'(stride_ff);
      end
      if (cmd.load_alloc) begin
         slot_idx_ff <= IDX_W'(32'(slot_ff));
         cpu_ff      <= cpu_base_ff + offset;
         gpu_ff      <= (kind_ff <= KIND_LAST_GPU) ? gpu_base_ff + offset : '0;
         status_ff   <= STATUS_ALLOCATED;
      end else if (cmd.load_full || cmd.load_freed) begin
         slot_idx_ff <= '0;
         cpu_ff      <= '0;
         gpu_ff      <= '0;
         status_ff   <= cmd.load_full ? STATUS_FULL : STATUS_FREED;
      end
   end

   assign rsp_slot_index = slot_idx_ff;
   assign rsp_cpu_addr   = cpu_ff;
   assign rsp_gpu_addr   = gpu_ff;
   assign rsp_status     = status_ff;

endmodule

// ===== hw/rtl/bsa_ctrl.sv =====
// Controller: sequences the scan, free and handle computation.
module bsa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_mode,
   output logic                 busy,
   output logic                 rsp_valid,
   output bsa_pkg::bsa_cmd_type cmd,
   input  bsa_pkg::bsa_sts_type sts
);
   import bsa_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FREE,
      ST_MUL,
      ST_ADD
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      busy_in      = busy_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               busy_in    = 1'b1;
               if (req_mode == MODE_FREE) begin
                  cmd.rd_free = 1'b1;
                  state_in    = ST_FREE;
               end else begin
                  cmd.rd_first = 1'b1;
                  state_in     = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (sts.hit) begin
               cmd.take_hit = 1'b1;
               state_in     = ST_MUL;
            end else if (sts.last_word) begin
               cmd.load_full = 1'b1;
               rsp_valid_in  = 1'b1;
               busy_in       = 1'b0;
               state_in      = ST_IDLE;
            end else begin
               cmd.rd_next = 1'b1;
            end
         end
         ST_FREE: begin
            cmd.do_free    = 1'b1;
            cmd.load_freed = 1'b1;
            rsp_valid_in   = 1'b1;
            busy_in        = 1'b0;
            state_in       = ST_IDLE;
         end
         ST_MUL: begin
            cmd.do_mul = 1'b1;
            state_in   = ST_ADD;
         end
         ST_ADD: begin
            cmd.load_alloc = 1'b1;
            rsp_valid_in   = 1'b1;
            busy_in        = 1'b0;
            state_in       = ST_IDLE;
         end
         default: begin
            busy_in  = 1'b0;
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/bitmap_slot_allocator.sv =====
// Top level of the bitmap slot allocator: controller, datapath and CSR port.
//
// Requests: drive req_mode and req_free_index and pulse start while busy is
// low; the request transfers at that edge and busy rises for its duration.
// req_mode 0 allocates the lowest free slot below the capacity, req_mode 1
// releases slot req_free_index (no double-free check).
// Results: every request yields one result, shown on the rsp_ ports for a
// single cycle while rsp_valid is high. The receiver cannot stall it, so
// capture it in that cycle; the result register sits apart from the
// request side, so a new request may start in the cycle the result shows.
// Sequence: a free reads its bitmap word, then writes it back with the bit set.
// An allocate scans from word zero until a word holds a usable free slot; a full
// heap answers once the last word has none. The scan reads one 64-bit bitmap
// word per cycle from the RAM, then forms slot times stride and after that the
// base additions.
// Configuration: csr_ready is always high; a write transfers on csr_valid and
// lands in the register named by csr_index (unknown indexes are dropped).
// Write only while the block is idle.
// Reset: synchronous; all slots become free at once through per-word valid
// bits, configuration returns to its defaults, no clearing pass is needed.
module bitmap_slot_allocator #(
   parameter int NUM_WORDS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_mode,
   input  logic [bsa_pkg::IDX_W-1:0]     req_free_index,
   output logic                          rsp_valid,
   output logic [bsa_pkg::IDX_W-1:0]     rsp_slot_index,
   output logic [63:0]                   rsp_cpu_addr,
   output logic [63:0]                   rsp_gpu_addr,
   output logic [bsa_pkg::STATUS_W-1:0]  rsp_status,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bsa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]                   csr_wdata
);
   import bsa_pkg::*;

   bsa_cmd_type cmd;
   bsa_sts_type sts;

   // Always able to take a configuration transfer.
   assign csr_ready = 1'b1;

   bsa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .cmd      (cmd),
      .sts      (sts)
   );

   bsa_datapath #(
      .NUM_WORDS(NUM_WORDS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_free_index(req_free_index),
      .csr_write     (csr_valid & csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_slot_index(rsp_slot_index),
      .rsp_cpu_addr  (rsp_cpu_addr),
      .rsp_gpu_addr  (rsp_gpu_addr),
      .rsp_status    (rsp_status)
   );

endmodule
